FILE: rtl/lr_pkg.sv
package lr_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int SIZE_BITS          = 13;
  localparam int COLOUR_BITS        = 24;
  localparam int CFG_DATA_BITS      = 32;
  localparam int CFG_ADDR_BITS      = 3;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

endpackage

FILE: rtl/lr_channels.sv
interface lr_req_if
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  finish_x;
  logic signed [COORD_BITS-1:0]  finish_y;
  logic        [COLOUR_BITS-1:0] line_colour;

  modport source (output valid, req_type, start_x, start_y, finish_x, finish_y, line_colour,
                  input ready);
  modport sink (input valid, req_type, start_x, start_y, finish_x, finish_y, line_colour,
                output ready);
endinterface

interface lr_point_if
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;
  logic        [COLOUR_BITS-1:0] point_colour;
  logic                          visible;
  logic                          line_end;
  logic                          last;

  modport source (output valid, point_x, point_y, point_colour, visible, line_end, last,
                  input ready);
  modport sink (input valid, point_x, point_y, point_colour, visible, line_end, last,
                output ready);
endinterface

FILE: rtl/line_rasterizer.sv
// Line engine: a start transaction sets up a line and yields no point; a step on an
// active line runs one iteration and queues one or two points. Points are registered
// in a four-entry queue and leave one per cycle while the point sink is ready. Rate is
// one transaction per cycle while at most two points are queued, bounded by the queue
// draining one point per cycle when a step yields two. Synchronous reset clears the
// queue, drops any line in progress and restores the 640 by 480 screen size.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  lr_req_if.sink                   req,
  lr_point_if.source               pt
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int EW = C + 3;
  localparam int VW = ((C > SIZE_BITS) ? C : SIZE_BITS) + 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [C-1:0]           x;
    logic [C-1:0]           y;
    logic [COLOUR_BITS-1:0] colour;
    logic                   visible;
    logic                   line_end;
    logic                   last;
  } point_t;

  // configuration
  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;
  logic                 cfg_write;
  reg_index_t           cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_BITS'(screen_height);
      default:           prdata = '0;
    endcase
  end

  // line state
  logic signed [C-1:0]    cursor_x;
  logic signed [C-1:0]    cursor_y;
  logic signed [C-1:0]    target_x;
  logic signed [C-1:0]    target_y;
  logic        [DW-1:0]   delta_x;
  logic        [DW-1:0]   delta_y;
  logic                   step_x_negative;
  logic                   step_y_negative;
  logic signed [EW-1:0]   error_term;
  logic [COLOUR_BITS-1:0] held_colour;
  logic                   line_active;

  logic                 req_accept;
  logic                 is_start;
  logic                 is_step;
  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] diff_y;
  logic        [DW-1:0] abs_x;
  logic        [DW-1:0] abs_y;
  logic signed [EW:0]   doubled;
  logic                 move_x;
  logic                 move_y;
  logic signed [C-1:0]  next_x;
  logic                 at_target;
  logic                 hit_after_x;
  logic signed [EW-1:0] error_after_x;
  logic [1:0]           push_count;
  point_t               res0;
  point_t               res1;
  point_t               head;
  logic                 queue_not_empty;
  logic [CNT_BITS-1:0]  queue_count;

  function automatic logic on_screen(input logic [C-1:0] x, input logic [C-1:0] y,
                                     input logic [SIZE_BITS-1:0] w,
                                     input logic [SIZE_BITS-1:0] h);
    logic [VW-1:0] xe;
    logic [VW-1:0] ye;
    logic [VW-1:0] we;
    logic [VW-1:0] he;
    xe = VW'(x);
    ye = VW'(y);
    we = VW'(w);
    he = VW'(h);
    return !x[C-1] && !y[C-1] && (xe < we) && (ye < he);
  endfunction

  assign req.ready  = (queue_count <= CNT_BITS'(QUEUE_DEPTH - 2));
  assign req_accept = req.valid && req.ready;
  assign is_start   = req_accept && (req_kind_t'(req.req_type) == REQ_START);
  assign is_step    = req_accept && (req_kind_t'(req.req_type) == REQ_STEP) && line_active;

  // setup
  assign diff_x = DW'(req.finish_x) - DW'(req.start_x);
  assign diff_y = DW'(req.finish_y) - DW'(req.start_y);
  assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

  // one iteration
  assign doubled       = (EW+1)'(error_term) <<< 1;
  assign move_x        = doubled > -$signed((EW+1)'(delta_y));
  assign move_y        = doubled < $signed((EW+1)'(delta_x));
  assign next_x        = step_x_negative ? C'(cursor_x - C'(1)) : C'(cursor_x + C'(1));
  assign at_target     = (cursor_x == target_x) && (cursor_y == target_y);
  assign hit_after_x   = move_x && (next_x == target_x) && (cursor_y == target_y);
  assign error_after_x = move_x ? EW'(error_term - EW'(delta_y)) : error_term;

  always_comb begin
    res0.x        = cursor_x;
    res0.y        = cursor_y;
    res0.colour   = held_colour;
    res0.visible  = on_screen(cursor_x, cursor_y, screen_width, screen_height);
    res0.line_end = at_target;
    res0.last     = at_target || !hit_after_x;
    res1.x        = next_x;
    res1.y        = cursor_y;
    res1.colour   = held_colour;
    res1.visible  = on_screen(next_x, cursor_y, screen_width, screen_height);
    res1.line_end = 1'b1;
    res1.last     = 1'b1;
    if (!is_step) begin
      push_count = 2'd0;
    end else if (!at_target && hit_after_x) begin
      push_count = 2'd2;
    end else begin
      push_count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (is_start) begin
      line_active <= 1'b1;
    end else if (is_step && (at_target || hit_after_x)) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_start) begin
      cursor_x        <= req.start_x;
      cursor_y        <= req.start_y;
      target_x        <= req.finish_x;
      target_y        <= req.finish_y;
      held_colour     <= req.line_colour;
      delta_x         <= abs_x;
      delta_y         <= abs_y;
      step_x_negative <= !(req.start_x < req.finish_x);
      step_y_negative <= !(req.start_y < req.finish_y);
      error_term      <= EW'(abs_x) - EW'(abs_y);
    end else if (is_step && !at_target) begin
      if (move_x) begin
        cursor_x <= next_x;
      end
      if (!hit_after_x && move_y) begin
        cursor_y   <= step_y_negative ? C'(cursor_y - C'(1)) : C'(cursor_y + C'(1));
        error_term <= EW'(error_after_x + EW'(delta_x));
      end else begin
        error_term <= error_after_x;
      end
    end
  end

  lr_out_queue #(
    .WIDTH ($bits(point_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_data0 (res0),
    .push_data1 (res1),
    .pop        (pt.ready),
    .not_empty  (queue_not_empty),
    .head       (head),
    .count      (queue_count)
  );

  assign pt.valid        = queue_not_empty;
  assign pt.point_x      = head.x;
  assign pt.point_y      = head.y;
  assign pt.point_colour = head.colour;
  assign pt.visible      = head.visible;
  assign pt.line_end     = head.line_end;
  assign pt.last         = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_start_activates: assert property (@(posedge clk) disable iff (rst)
    is_start |=> line_active)
    else $error("start did not activate line");

  a_end_step_drops: assert property (@(posedge clk) disable iff (rst)
    (is_step && at_target) |=> (!line_active && queue_not_empty))
    else $error("final step left line active or queued nothing");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (!line_active && !is_start) |-> (push_count == 2'd0))
    else $error("point queued with no line active");

endmodule

FILE: rtl/lr_out_queue.sv
module lr_out_queue
  import lr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 push_count,
  input  logic [WIDTH-1:0]           push_data0,
  input  logic [WIDTH-1:0]           push_data1,
  input  logic                       pop,
  output logic                       not_empty,
  output logic [WIDTH-1:0]           head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH+1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS-1:0] wr_ptr_plus1;
  logic                do_pop;

  assign not_empty    = (count != '0);
  assign head         = slots[rd_ptr];
  assign do_pop       = pop && not_empty;
  assign wr_ptr_plus1 = PTR_BITS'((32'(wr_ptr) + 1) % DEPTH);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_data0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr_plus1] <= push_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_BITS'((32'(wr_ptr) + 32'(push_count)) % DEPTH);
      if (do_pop) begin
        rd_ptr <= PTR_BITS'((32'(rd_ptr) + 1) % DEPTH);
      end
      count <= CNT_BITS'(32'(count) + 32'(push_count) - (do_pop ? 32'd1 : 32'd0));
    end
  end

endmodule
